>>> rtl/core/shi_pkg.sv
// ---------------------------------------------------------------------------
// shi_pkg: shared types for the hazard/issue pipeline model
// Instruction record held in every pipeline slot and the per-cycle result.
// ---------------------------------------------------------------------------
`default_nettype none

package shi_pkg;

  // Configuration register indexes
  localparam logic REG_EXEC_FWD = 1'b0;
  localparam logic REG_MEM_FWD  = 1'b1;

  // One instruction as it travels through fetch, decode, execute and memory
  typedef struct packed {
    logic       is_load;
    logic [7:0] dest_reg;
    logic       dest_used;
    logic [7:0] src_a_reg;
    logic       src_a_used;
    logic [7:0] src_b_reg;
    logic       src_b_used;
    logic       reads_flags;
    logic       writes_flags;
    logic       final_instr;
  } instr_t;

  // One simulated pipeline cycle
  typedef struct packed {
    logic [31:0] cycle_number;
    logic [3:0]  retired_now;
    logic [31:0] retired_total;
    logic        halted;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/shi_front.sv
// ---------------------------------------------------------------------------
// shi_front: instruction intake
// Packs the incoming fields into an instruction record and buffers it in a
// two-entry queue so the back end can stall without blocking intake.
// ---------------------------------------------------------------------------
`default_nettype none

module shi_front
  import shi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic       is_load_i,
  input  wire logic [7:0] dest_reg_i,
  input  wire logic       dest_used_i,
  input  wire logic [7:0] src_a_reg_i,
  input  wire logic       src_a_used_i,
  input  wire logic [7:0] src_b_reg_i,
  input  wire logic       src_b_used_i,
  input  wire logic       reads_flags_i,
  input  wire logic       writes_flags_i,
  input  wire logic       final_instr_i,
  output logic            valid_o,
  output instr_t          instr_o,
  input  wire logic       pop_i
);

  instr_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  instr_t     rec;

  // Pack the transfer into a record
  always_comb begin
    rec.is_load      = is_load_i;
    rec.dest_reg     = dest_reg_i;
    rec.dest_used    = dest_used_i;
    rec.src_a_reg    = src_a_reg_i;
    rec.src_a_used   = src_a_used_i;
    rec.src_b_reg    = src_b_reg_i;
    rec.src_b_used   = src_b_used_i;
    rec.reads_flags  = reads_flags_i;
    rec.writes_flags = writes_flags_i;
    rec.final_instr  = final_instr_i;
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign instr_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/shi_res_q.sv
// ---------------------------------------------------------------------------
// shi_res_q: result queue
// Two-entry queue between the cycle engine and the result port.
// ---------------------------------------------------------------------------
`default_nettype none

module shi_res_q
  import shi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   data_i,
  output logic      full_o,
  output logic      empty_o,
  output result_t   data_o,
  input  wire logic pop_i
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/shi_back.sv
// ---------------------------------------------------------------------------
// shi_back: pipeline cycle engine
// Holds the fetch/decode/execute/memory latches, places each instruction in
// fetch and steps whole pipeline cycles, one per clock while the result queue
// is not full, emitting one result per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module shi_back
  import shi_pkg::*;
#(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic cfg_data_i,
  input  wire logic q_valid_i,
  input  instr_t    q_instr_i,
  output logic      q_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output result_t   res_data_o
);

  localparam int unsigned CW        = $clog2(SLOTS + 1);
  localparam int unsigned MaxCycles = 32;
  localparam int unsigned NW        = $clog2(MaxCycles + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e          state_q;
  logic [NW-1:0]   n_q;
  logic            fin_mode_q, halt_seen_q;
  logic            exec_fwd_q, mem_fwd_q;
  logic [31:0]     cyc_q, ret_q;
  logic [SLOTS-1:0] fv_q, dv_q, ev_q, mv_q;
  instr_t          f_q [SLOTS];
  instr_t          d_q [SLOTS];
  instr_t          e_q [SLOTS];
  instr_t          m_q [SLOTS];

  logic            fwd, run_cond, do_insert, do_cycle, halted;
  logic [SLOTS-1:0] ins_sel, stall, issue, fv_d;
  instr_t          f_d [SLOTS];
  logic [CW-1:0]   moved;
  logic [3:0]      retired;

  function automatic logic hz(instr_t c, instr_t p);
    logic r;
    r = (c.reads_flags && p.writes_flags) ||
        (p.dest_used && ((c.src_a_used && c.src_a_reg == p.dest_reg) ||
                         (c.src_b_used && c.src_b_reg == p.dest_reg)));
    return r;
  endfunction

  assign fwd = exec_fwd_q && mem_fwd_q;

  // Loop condition of the current instruction's step
  assign run_cond = (n_q < NW'(MaxCycles)) && (fin_mode_q ? !halt_seen_q : (&fv_q));
  assign do_insert = (state_q == ST_IDLE) && q_valid_i;
  assign do_cycle  = (state_q == ST_RUN) && run_cond && !res_full_i;
  assign q_pop_o   = do_insert;
  assign res_push_o = do_cycle;

  // Pick the highest free fetch slot, just below the occupied ones
  always_comb begin
    logic above;
    above = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      ins_sel[i] = !fv_q[i] && above;
      above      = above && fv_q[i];
    end
  end

  // Retire count and halt detect
  always_comb begin
    retired = 4'd0;
    halted  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      retired = retired + 4'(mv_q[i]);
      halted  = halted || (mv_q[i] && m_q[i].final_instr);
    end
  end

  // Hazards against the shifted execute (old decode), memory (old execute)
  // and older fetch entries
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      stall[i] = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        if (dv_q[k] && (!fwd || d_q[k].is_load) && hz(f_q[i], d_q[k])) stall[i] = 1'b1;
        if (!fwd && ev_q[k] && hz(f_q[i], e_q[k])) stall[i] = 1'b1;
        if (k > i && fv_q[k] && hz(f_q[i], f_q[k])) stall[i] = 1'b1;
      end
      stall[i] = stall[i] && fv_q[i];
    end
  end

  // Issue from the top down until the first stalled slot
  always_comb begin
    logic go;
    go    = 1'b1;
    moved = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      go       = go && !stall[i];
      issue[i] = go;
      moved    = moved + CW'(go);
    end
  end

  // Shift the remaining fetch entries up by the issue count
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      fv_d[i] = 1'b0;
      f_d[i]  = f_q[i];
      for (int m = 0; m <= i; m++) begin
        if (moved == CW'(m)) begin
          fv_d[i] = fv_q[i - m];
          f_d[i]  = f_q[i - m];
        end
      end
    end
  end

  // Result of this cycle
  always_comb begin
    res_data_o.cycle_number  = cyc_q + 32'd1;
    res_data_o.retired_now   = retired;
    res_data_o.retired_total = ret_q + 32'(retired);
    res_data_o.halted        = halted;
  end

  // Slot payloads
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (ins_sel[i]) f_q[i] <= q_instr_i;
      end
    end else if (do_cycle) begin
      for (int i = 0; i < SLOTS; i++) begin
        m_q[i] <= e_q[i];
        e_q[i] <= d_q[i];
        d_q[i] <= f_q[i];
        f_q[i] <= f_d[i];
      end
    end
  end

  // Sequencer, valid bits, counters and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      fin_mode_q  <= 1'b0;
      halt_seen_q <= 1'b0;
      exec_fwd_q  <= 1'b0;
      mem_fwd_q   <= 1'b0;
      cyc_q       <= 32'd0;
      ret_q       <= 32'd0;
      fv_q        <= '0;
      dv_q        <= '0;
      ev_q        <= '0;
      mv_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EXEC_FWD: exec_fwd_q <= cfg_data_i;
          REG_MEM_FWD:  mem_fwd_q  <= cfg_data_i;
          default:      exec_fwd_q <= exec_fwd_q;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (do_insert) begin
            fv_q        <= fv_q | ins_sel;
            fin_mode_q  <= q_instr_i.final_instr;
            halt_seen_q <= 1'b0;
            n_q         <= '0;
            state_q     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!run_cond) begin
            state_q <= ST_IDLE;
          end else if (do_cycle) begin
            mv_q        <= ev_q;
            ev_q        <= dv_q;
            dv_q        <= fv_q & issue;
            fv_q        <= fv_d;
            cyc_q       <= res_data_o.cycle_number;
            ret_q       <= res_data_o.retired_total;
            halt_seen_q <= halted;
            n_q         <= n_q + NW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/superscalar_hazard_issue.sv
// ---------------------------------------------------------------------------
// superscalar_hazard_issue: in-order superscalar interlock model
// Accepts one instruction per transfer and emits one result per simulated
// pipeline cycle.
//
//   channel   handshake        payload
//   input     push / full      is_load_i .. final_instr_i
//   result    empty / pop      cycle_number_o, retired_now_o,
//                              retired_total_o, halted_o
//   config    cfg_we_i         cfg_idx_i, cfg_data_i
//
// Each instruction is first placed in fetch, then triggers 0 to 32 simulated
// pipeline cycles, while fetch is full or, for a final instruction, until
// a halt is seen; its step then closes with a return to idle.
// Reset clears all valid bits, counters and forwarding enables.
// A full result queue stalls the engine; the two-entry input queue keeps
// taking transfers meanwhile until it is full.
// ---------------------------------------------------------------------------
`default_nettype none

module superscalar_hazard_issue
  import shi_pkg::*;
#(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        is_load_i,
  input  wire logic [7:0]  dest_reg_i,
  input  wire logic        dest_used_i,
  input  wire logic [7:0]  src_a_reg_i,
  input  wire logic        src_a_used_i,
  input  wire logic [7:0]  src_b_reg_i,
  input  wire logic        src_b_used_i,
  input  wire logic        reads_flags_i,
  input  wire logic        writes_flags_i,
  input  wire logic        final_instr_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      cycle_number_o,
  output logic [3:0]       retired_now_o,
  output logic [31:0]      retired_total_o,
  output logic             halted_o
);

  logic    q_valid, q_pop, res_full, res_push;
  instr_t  q_instr;
  result_t res_in, res_out;

  shi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .is_load_i      (is_load_i),
    .dest_reg_i     (dest_reg_i),
    .dest_used_i    (dest_used_i),
    .src_a_reg_i    (src_a_reg_i),
    .src_a_used_i   (src_a_used_i),
    .src_b_reg_i    (src_b_reg_i),
    .src_b_used_i   (src_b_used_i),
    .reads_flags_i  (reads_flags_i),
    .writes_flags_i (writes_flags_i),
    .final_instr_i  (final_instr_i),
    .valid_o        (q_valid),
    .instr_o        (q_instr),
    .pop_i          (q_pop)
  );

  shi_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_instr_i  (q_instr),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_data_o (res_in)
  );

  shi_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .data_o  (res_out),
    .pop_i   (pop)
  );

  assign cycle_number_o  = res_out.cycle_number;
  assign retired_now_o   = res_out.retired_now;
  assign retired_total_o = res_out.retired_total;
  assign halted_o        = res_out.halted;

  // Engine never pushes into a full result queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed while queue full");

  // Engine never pops an empty intake queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("intake popped while empty");

  // A halting cycle always retires something
  a_halt_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && halted_o) |-> (retired_now_o != 4'd0))
    else $error("halt reported without retirement");

endmodule

`default_nettype wire
